/* hdl/lexicographic_topological_sort_defines.svh */
// assertion helpers used by lts_back
`ifndef LEXICOGRAPHIC_TOPOLOGICAL_SORT_DEFINES_SVH
`define LEXICOGRAPHIC_TOPOLOGICAL_SORT_DEFINES_SVH

`ifndef SYNTH
`define LTS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LTS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/lts_pkg.sv */
package lts_pkg;

	localparam int NODE_W = 7;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_EDGE  = 2'd1;
	localparam logic [1:0] OP_SORT  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_EDGE,
		CMD_DROP,
		CMD_SORT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [NODE_W-1:0] first;
		logic [NODE_W-1:0] second;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              last;
		logic              complete;
		logic              dropped;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_ADD_WR,
		B_INIT,
		B_PICK,
		B_SCAN_RD,
		B_SCAN_CHK,
		B_SCAN_DEC,
		B_EMIT_RD,
		B_EMIT_WR
	} back_state_t;

endpackage

/* hdl/lts_fifo.sv */
module lts_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

/* hdl/lts_front.sv */
module lts_front (
	input  logic                       push,
	input  logic [1:0]                 op,
	input  logic [lts_pkg::NODE_W-1:0] first_node,
	input  logic [lts_pkg::NODE_W-1:0] second_node,
	input  logic [lts_pkg::NODE_W-1:0] eff_nodes,
	input  logic                       q_full,
	output logic                       q_push,
	output lts_pkg::cmd_t              q_cmd
);
	import lts_pkg::*;

	logic in_range;

	// end points must lie in 1..eff_nodes
	assign in_range = (first_node != '0) && (first_node <= eff_nodes)
		&& (second_node != '0) && (second_node <= eff_nodes);

	always_comb begin
		q_cmd.first  = first_node;
		q_cmd.second = second_node;
		q_cmd.kind   = CMD_CLEAR;
		q_push       = push && !q_full;
		unique case (op)
			OP_CLEAR: q_cmd.kind = CMD_CLEAR;
			OP_EDGE:  q_cmd.kind = in_range ? CMD_EDGE : CMD_DROP;
			OP_SORT:  q_cmd.kind = CMD_SORT;
			default:  q_push = 1'b0;
		endcase
	end

endmodule

/* hdl/lts_back.sv */
`include "lexicographic_topological_sort_defines.svh"

module lts_back #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lts_pkg::NODE_W-1:0] eff_nodes,
	input  logic                       cmd_valid,
	input  lts_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	input  logic                       out_full,
	output logic                       out_push,
	output lts_pkg::res_t              out_res
);
	import lts_pkg::*;

	localparam int NI_W = $clog2(MAX_NODES);
	localparam int OT_W = $clog2(MAX_NODES + 1);
	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ET_W = $clog2(MAX_EDGES + 1);
	localparam int CNT_W = $clog2(MAX_EDGES + 1);

	back_state_t state_q, state_d;

	// counts are stored in a memory; zero_q marks counts that are zero
	logic [MAX_NODES-1:0] zero_q;
	logic [MAX_NODES-1:0] ready_q;
	logic [ET_W-1:0]      edge_total_q;
	logic [OT_W-1:0]      order_total_q;
	logic                 dropped_q;
	logic [NI_W-1:0]      a_idx_q;
	logic [NI_W-1:0]      pick_q;
	logic [NI_W-1:0]      from_q;
	logic [ET_W-1:0]      scan_k_q;
	logic [OT_W-1:0]      emit_k_q;

	logic [CNT_W-1:0]  pend_mem [MAX_NODES];
	logic [CNT_W-1:0]  pend_rdata;
	logic              pend_re, pend_we;
	logic [NI_W-1:0]   pend_raddr, pend_waddr;
	logic [CNT_W-1:0]  pend_wdata;

	logic [2*NI_W-1:0] edge_mem [MAX_EDGES];
	logic [2*NI_W-1:0] edge_rdata;
	logic              edge_re, edge_we;

	logic [NI_W-1:0]   order_mem [MAX_NODES];
	logic [NI_W-1:0]   order_rdata;
	logic              order_re, order_we;

	logic [MAX_NODES-1:0] node_mask;
	logic                 pick_found;
	logic [NI_W-1:0]      pick_idx;
	logic [NI_W-1:0]      cmd_a_idx, cmd_b_idx;
	logic [NI_W-1:0]      e_from, e_to;
	logic                 e_hit;
	logic [CNT_W-1:0]     dec_val;
	logic                 edges_full;
	logic                 emit_last;

	assign cmd_a_idx  = NI_W'(cmd.first - NODE_W'(1));
	assign cmd_b_idx  = NI_W'(cmd.second - NODE_W'(1));
	assign e_from     = edge_rdata[2*NI_W-1:NI_W];
	assign e_to       = edge_rdata[NI_W-1:0];
	assign e_hit      = (e_to == pick_q) && (32'(e_from) < 32'(eff_nodes)) && !zero_q[e_from];
	assign dec_val    = pend_rdata - CNT_W'(1);
	assign edges_full = 32'(edge_total_q) >= MAX_EDGES;
	assign emit_last  = emit_k_q == OT_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) node_mask[i] = 32'(i) < 32'(eff_nodes);
	end

	// highest-numbered ready node
	always_comb begin
		pick_found = 1'b0;
		pick_idx   = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (ready_q[i]) begin
				pick_found = 1'b1;
				pick_idx   = NI_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_SORT) state_d = B_INIT;
					else if (cmd.kind == CMD_EDGE && !edges_full) state_d = B_ADD_WR;
				end
			end
			B_ADD_WR:   state_d = B_IDLE;
			B_INIT:     state_d = B_PICK;
			B_PICK:     state_d = pick_found ? B_SCAN_RD : B_EMIT_RD;
			B_SCAN_RD:  state_d = (scan_k_q == edge_total_q) ? B_PICK : B_SCAN_CHK;
			B_SCAN_CHK: state_d = e_hit ? B_SCAN_DEC : B_SCAN_RD;
			B_SCAN_DEC: state_d = B_SCAN_RD;
			B_EMIT_RD: begin
				if (order_total_q == '0) begin
					if (!out_full) state_d = B_IDLE;
				end else begin
					state_d = B_EMIT_WR;
				end
			end
			B_EMIT_WR: begin
				if (!out_full) state_d = emit_last ? B_IDLE : B_EMIT_RD;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		pend_re    = 1'b0;
		pend_we    = 1'b0;
		pend_raddr = cmd_a_idx;
		pend_waddr = a_idx_q;
		pend_wdata = (zero_q[a_idx_q] ? '0 : pend_rdata) + CNT_W'(1);
		edge_re    = 1'b0;
		edge_we    = 1'b0;
		order_re   = 1'b0;
		order_we   = 1'b0;
		out_push   = 1'b0;
		out_res    = '0;
		unique case (state_q)
			B_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && cmd.kind == CMD_EDGE && !edges_full) begin
					pend_re = 1'b1;
					edge_we = 1'b1;
				end
			end
			B_ADD_WR: pend_we = 1'b1;
			B_PICK:   order_we = pick_found;
			B_SCAN_RD: edge_re = scan_k_q != edge_total_q;
			B_SCAN_CHK: begin
				pend_re    = e_hit;
				pend_raddr = e_from;
			end
			B_SCAN_DEC: begin
				pend_we    = 1'b1;
				pend_waddr = from_q;
				pend_wdata = dec_val;
			end
			B_EMIT_RD: begin
				if (order_total_q == '0) begin
					// nothing ordered: a single closing result with node 0
					out_push         = !out_full;
					out_res.last     = 1'b1;
					out_res.complete = eff_nodes == '0;
					out_res.dropped  = dropped_q;
				end else begin
					order_re = 1'b1;
				end
			end
			B_EMIT_WR: begin
				out_push         = !out_full;
				out_res.node     = NODE_W'(order_rdata) + NODE_W'(1);
				out_res.last     = emit_last;
				out_res.complete = emit_last && (32'(order_total_q) == 32'(eff_nodes));
				out_res.dropped  = emit_last && dropped_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			zero_q        <= '1;
			ready_q       <= '0;
			edge_total_q  <= '0;
			order_total_q <= '0;
			dropped_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_CLEAR: begin
								zero_q        <= '1;
								ready_q       <= '0;
								edge_total_q  <= '0;
								order_total_q <= '0;
								dropped_q     <= 1'b0;
							end
							CMD_DROP: dropped_q <= 1'b1;
							CMD_EDGE: begin
								if (edges_full) dropped_q <= 1'b1;
								else edge_total_q <= edge_total_q + ET_W'(1);
							end
							CMD_SORT: ;
							default: ;
						endcase
					end
				end
				B_ADD_WR: zero_q[a_idx_q] <= 1'b0;
				B_INIT: begin
					ready_q       <= zero_q & node_mask;
					order_total_q <= '0;
				end
				B_PICK: begin
					if (pick_found) begin
						ready_q[pick_idx] <= 1'b0;
						order_total_q     <= order_total_q + OT_W'(1);
					end
				end
				B_SCAN_DEC: begin
					if (dec_val == '0) begin
						zero_q[from_q]  <= 1'b1;
						ready_q[from_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) a_idx_q <= cmd_a_idx;
		if (state_q == B_PICK) begin
			pick_q   <= pick_idx;
			scan_k_q <= '0;
			emit_k_q <= order_total_q;
		end
		if (state_q == B_SCAN_CHK) begin
			from_q <= e_from;
			if (!e_hit) scan_k_q <= scan_k_q + ET_W'(1);
		end
		if (state_q == B_SCAN_DEC) scan_k_q <= scan_k_q + ET_W'(1);
		if (state_q == B_EMIT_WR && !out_full) emit_k_q <= emit_k_q - OT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
		if (pend_re) pend_rdata <= pend_mem[pend_raddr];
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_total_q[EA_W-1:0]] <= {cmd_a_idx, cmd_b_idx};
		if (edge_re) edge_rdata <= edge_mem[scan_k_q[EA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (order_we) order_mem[order_total_q[NI_W-1:0]] <= pick_idx;
		if (order_re) order_rdata <= order_mem[NI_W'(emit_k_q - OT_W'(1))];
	end

	`LTS_ASSERT_ALWAYS(a_ready_zero, clk, arst_n, (ready_q & ~zero_q) == '0)
	`LTS_ASSERT_ALWAYS(a_order_cap, clk, arst_n, 32'(order_total_q) <= MAX_NODES)
	`LTS_ASSERT_NEXT(a_sort_start, clk, arst_n, state_q == B_IDLE && cmd_valid && cmd.kind == CMD_SORT, state_q == B_INIT)

endmodule

/* hdl/lexicographic_topological_sort.sv */
// clear and dropped edges finish in the back end's idle state; kept edges also pass
// B_ADD_WR. throughput: one request per cycle while the two-entry queue has room;
// the back end sets the pace. sort: each ordered node scans every stored edge, with
// a decrement on a hit (one edge store port), then a read and write per result
// reset: arst_n clears the graph, node_count and both queues; no clearing pass
module lexicographic_topological_sort #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [6:0]  first_node,
	input  logic [6:0]  second_node,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  node,
	output logic        last,
	output logic        complete,
	output logic        edges_dropped
);
	import lts_pkg::*;

	localparam int CAP = (MAX_NODES > 127) ? 127 : MAX_NODES;

	logic [NODE_W-1:0] node_count_q;
	logic [NODE_W-1:0] eff_nodes;
	logic              cq_push, cq_full, cq_empty, cq_pop;
	cmd_t              cq_din, cq_dout;
	logic              oq_push, oq_full;
	res_t              oq_din, oq_dout;

	assign pready    = 1'b1;
	assign prdata    = (paddr == REG_NODE_COUNT) ? {25'd0, node_count_q} : 32'd0;
	assign eff_nodes = (32'(node_count_q) > MAX_NODES) ? NODE_W'(CAP) : node_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= '0;
		else if (psel && penable && pwrite) node_count_q <= pwdata[NODE_W-1:0];
	end

	lts_front u_front (
		.push       (push),
		.op         (op),
		.first_node (first_node),
		.second_node(second_node),
		.eff_nodes  (eff_nodes),
		.q_full     (cq_full),
		.q_push     (cq_push),
		.q_cmd      (cq_din)
	);

	assign full = cq_full;

	lts_fifo #(.W($bits(cmd_t))) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.din   (cq_din),
		.full  (cq_full),
		.pop   (cq_pop),
		.dout  (cq_dout),
		.empty (cq_empty)
	);

	lts_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_nodes(eff_nodes),
		.cmd_valid(!cq_empty),
		.cmd      (cq_dout),
		.cmd_pop  (cq_pop),
		.out_full (oq_full),
		.out_push (oq_push),
		.out_res  (oq_din)
	);

	lts_fifo #(.W($bits(res_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (oq_push),
		.din   (oq_din),
		.full  (oq_full),
		.pop   (pop),
		.dout  (oq_dout),
		.empty (empty)
	);

	assign node          = oq_dout.node;
	assign last          = oq_dout.last;
	assign complete      = oq_dout.complete;
	assign edges_dropped = oq_dout.dropped;

endmodule

/* verif/lexicographic_topological_sort_checker.sv */
module lexicographic_topological_sort_checker #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  op,
	input  logic [6:0]  first_node,
	input  logic [6:0]  second_node,
	input  logic        empty,
	input  logic        pop,
	input  logic [6:0]  node,
	input  logic        last,
	input  logic        complete,
	input  logic        edges_dropped,
	output int          errors,
	output int          outstanding,
	output int          checked
);
	import lts_pkg::*;

	logic [6:0]  node_cnt;
	logic [10:0] pend [1:MAX_NODES];
	logic [6:0]  edge_src [$];
	logic [6:0]  edge_dst [$];
	logic        drop_seen;
	res_t        order_q [$];

	assign outstanding = order_q.size();

	function automatic void wipe_graph();
		for (int i = 1; i <= MAX_NODES; i++)
			pend[i] = '0;
		edge_src.delete();
		edge_dst.delete();
		drop_seen = 1'b0;
	endfunction

	function automatic void sort_graph();
		int  n;
		int  pick;
		int  removed [$];
		bit  ready [0:MAX_NODES];
		res_t r;
		n = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
		for (int i = 0; i <= MAX_NODES; i++)
			ready[i] = (i >= 1 && i <= n && pend[i] == 0);
		forever begin
			pick = 0;
			for (int i = n; i >= 1; i--)
				if (ready[i]) begin
					pick = i;
					break;
				end
			if (pick == 0)
				break;
			ready[pick] = 0;
			removed.insert(removed.size(), pick);
			foreach (edge_src[k]) begin
				if (edge_dst[k] != pick || edge_src[k] < 1 || edge_src[k] > n)
					continue;
				if (pend[edge_src[k]] > 0) begin
					pend[edge_src[k]]--;
					if (pend[edge_src[k]] == 0)
						ready[edge_src[k]] = 1;
				end
			end
		end
		if (removed.size() == 0) begin
			r.node = '0;
			r.last = 1'b1;
			r.complete = (n == 0);
			r.dropped = drop_seen;
			order_q.insert(order_q.size(), r);
		end else begin
			for (int k = removed.size() - 1; k >= 0; k--) begin
				r.node = NODE_W'(removed[k]);
				r.last = (k == 0);
				r.complete = (k == 0) && (removed.size() == n);
				r.dropped = (k == 0) && drop_seen;
				order_q.insert(order_q.size(), r);
			end
		end
	endfunction

	function automatic void apply_request(logic [1:0] o, logic [6:0] a, logic [6:0] b);
		int n;
		n = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
		case (o)
			OP_CLEAR: wipe_graph();
			OP_EDGE: begin
				if (edge_src.size() >= MAX_EDGES || a < 1 || a > n || b < 1 || b > n) begin
					drop_seen = 1'b1;
				end else begin
					edge_src.insert(edge_src.size(), a);
					edge_dst.insert(edge_dst.size(), b);
					pend[a]++;
				end
			end
			OP_SORT: sort_graph();
			OP_NONE: ;
		endcase
	endfunction

	function automatic void report(string what, int exp_v, int act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %0d got %0d (result %0d)",
				what, exp_v, act_v, checked);
	endfunction

	initial begin
		errors = 0;
		checked = 0;
		node_cnt = '0;
		wipe_graph();
	end

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			node_cnt = '0;
			wipe_graph();
			order_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_NODE_COUNT)
				node_cnt = pwdata[6:0];
			if (pop && !empty) begin
				if (order_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result node %0d last %0b", node, last);
				end else begin
					e = order_q.pop_front();
					if (node !== e.node) report("node", e.node, node);
					if (last !== e.last) report("last", e.last, last);
					if (complete !== e.complete) report("complete", e.complete, complete);
					if (edges_dropped !== e.dropped)
						report("edges_dropped", e.dropped, edges_dropped);
				end
				checked++;
			end
			if (push && !full)
				apply_request(op, first_node, second_node);
		end
	end

endmodule

/* verif/lexicographic_topological_sort_tb.sv */
module lexicographic_topological_sort_tb;
	import lts_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        push, full;
	logic [1:0]  op;
	logic [6:0]  first_node, second_node;
	logic        empty, pop;
	logic [6:0]  node;
	logic        last, complete, edges_dropped;
	int          errors, outstanding, checked;
	int          requests;
	int          hold_cycles;
	bit          calm;

	lexicographic_topological_sort u_dut (.*);

	lexicographic_topological_sort_checker u_chk (.*);

	always #1 clk = ~clk;

	task automatic send(logic [1:0] o, logic [6:0] a, logic [6:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= o;
		first_node <= a;
		second_node <= b;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		requests++;
	endtask

	// wait until every sort has drained, then let queued edges land
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_nodes(int v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_NODE_COUNT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// receiver: random stalls, quiet stretches, and one long hold-off on request
	initial begin
		int w;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			w = calm ? 0 : $urandom_range(0, 11);
			if (hold_cycles > 0) begin
				w = hold_cycles;
				hold_cycles = 0;
			end
			if (w > 0) begin
				pop <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int n, ne, sorts;
		logic [6:0] a, b;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		push = 1'b0; op = OP_CLEAR; first_node = '0; second_node = '0;
		requests = 0; hold_cycles = 0; calm = 1'b0; sorts = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sort on an empty node set straight out of reset
		send(OP_SORT, 7'd0, 7'd0);
		settle();
		// oversized count behaves as the maximum, no edges: every node in order
		set_nodes(127);
		send(OP_SORT, 7'd0, 7'd0);
		settle();
		set_nodes(5);
		send(OP_CLEAR, 7'd0, 7'd0);
		send(OP_EDGE, 7'd1, 7'd2);
		send(OP_EDGE, 7'd2, 7'd3);
		send(OP_EDGE, 7'd5, 7'd4);
		send(OP_EDGE, 7'd5, 7'd4);
		send(OP_EDGE, 7'd0, 7'd1);
		send(OP_EDGE, 7'd6, 7'd1);
		send(OP_EDGE, 7'd1, 7'd127);
		send(OP_NONE, 7'd127, 7'd127);
		send(OP_SORT, 7'd0, 7'd0);
		send(OP_SORT, 7'd0, 7'd0);
		send(OP_CLEAR, 7'd0, 7'd0);
		send(OP_EDGE, 7'd3, 7'd3);
		send(OP_EDGE, 7'd4, 7'd5);
		send(OP_EDGE, 7'd5, 7'd4);
		send(OP_EDGE, 7'd1, 7'd5);
		send(OP_SORT, 7'd0, 7'd0);
		settle();
		// lower the count with edges above it still stored
		send(OP_CLEAR, 7'd0, 7'd0);
		send(OP_EDGE, 7'd5, 7'd1);
		send(OP_EDGE, 7'd2, 7'd5);
		send(OP_EDGE, 7'd2, 7'd1);
		settle();
		set_nodes(3);
		send(OP_SORT, 7'd0, 7'd0);
		settle();
		set_nodes(64);
		send(OP_CLEAR, 7'd0, 7'd0);
		send(OP_EDGE, 7'd64, 7'd1);
		send(OP_EDGE, 7'd1, 7'd64);
		send(OP_SORT, 7'd0, 7'd0);
		settle();

		// receiver holds off while several sorts pile up
		set_nodes(64);
		hold_cycles = 600;
		send(OP_CLEAR, 7'd0, 7'd0);
		repeat (3) send(OP_SORT, 7'd0, 7'd0);
		send(OP_EDGE, 7'd7, 7'd9);
		send(OP_SORT, 7'd0, 7'd0);
		settle();

		// random graphs: mostly acyclic with some noise, cycles and reruns
		while (requests < 450) begin
			case ($urandom_range(0, 9))
				0: n = 0;
				1: n = 64;
				2: n = $urandom_range(65, 127);
				default: n = $urandom_range(1, 16);
			endcase
			calm = ($urandom_range(0, 5) == 0);
			set_nodes(n);
			if ($urandom_range(0, 4) != 0)
				send(OP_CLEAR, 7'd0, 7'd0);
			ne = $urandom_range(0, 30);
			for (int k = 0; k < ne; k++) begin
				a = 7'($urandom_range(1, (n > 64 || n == 0) ? 64 : n));
				b = 7'($urandom_range(1, (n > 64 || n == 0) ? 64 : n));
				case ($urandom_range(0, 9))
					0: send(OP_EDGE, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
					1: send(OP_NONE, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
					2: send(OP_EDGE, a, b);
					default: send(OP_EDGE, (a < b) ? a : b, (a < b) ? b : a);
				endcase
			end
			if ($urandom_range(0, 5) == 0) begin
				settle();
				set_nodes($urandom_range(0, 16));
			end
			send(OP_SORT, 7'd0, 7'd0);
			sorts++;
			if ($urandom_range(0, 3) == 0) begin
				send(OP_EDGE, 7'($urandom_range(0, 20)), 7'($urandom_range(0, 20)));
				send(OP_SORT, 7'd0, 7'd0);
				sorts++;
			end
			settle();
		end

		push <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d requests sent, %0d random sorts, %0d results compared",
			requests, sorts, checked);
		$display("covered clear, edge, sort, unknown op, dropped edges and cycles");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
